>>> src/protobuf_wire_stream_parser_unit_defines.svh
`ifndef PROTOBUF_WIRE_STREAM_PARSER_UNIT_DEFINES_SVH
`define PROTOBUF_WIRE_STREAM_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define PWSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define PWSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/pwsp_pkg.sv
`timescale 1ns / 1ps

package pwsp_pkg;

   localparam int VALUE_W     = 64;
   localparam int FIELD_W     = 32;
   localparam int VARINT_BITS = 7;
   localparam int VARINT_MAX  = (VALUE_W + VARINT_BITS - 1) / VARINT_BITS;
   localparam int VIDX_W      = $clog2(VARINT_MAX);
   localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(VARINT_MAX - 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] EV_VARINT  = 3'd0;
   localparam logic [2:0] EV_LENGTH  = 3'd1;
   localparam logic [2:0] EV_PAYLOAD = 3'd2;
   localparam logic [2:0] EV_END     = 3'd3;
   localparam logic [2:0] EV_ERROR   = 3'd4;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd1;
   localparam logic [2:0] ERR_VARINT_LONG = 3'd2;
   localparam logic [2:0] ERR_FIELD_ZERO = 3'd3;
   localparam logic [2:0] ERR_WIRE_TYPE  = 3'd4;

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LENGTH  = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   localparam logic [VALUE_W-1:0] FIXED64_BYTES = VALUE_W'(8);
   localparam logic [VALUE_W-1:0] FIXED32_BYTES = VALUE_W'(4);

   typedef enum logic [2:0] {
      PH_TAG,
      PH_VAL,
      PH_LEN,
      PH_PAY,
      PH_ERR
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]         event_kind;
      logic [FIELD_W-1:0] field_number;
      logic [2:0]         wire_type;
      logic [VALUE_W-1:0] field_value;
      logic [7:0]         payload_byte;
      logic [2:0]         error_code;
      logic               run_last;
   } rsp_type;

   // one parsed byte: an optional data/error event, then an optional buffer end
   typedef struct packed {
      logic    prim_valid;
      rsp_type prim;
      logic    end_valid;
   } entry_type;

endpackage

>>> src/protobuf_wire_stream_parser_unit.sv
`timescale 1ns / 1ps
// Channel    Ports                                  Moves
// request    req_push, req_full, req_item           one buffer byte and its last-byte flag
// response   rsp_pop, rsp_empty, rsp_item           one parse event
//
// A byte is taken every cycle while the 4-entry event queue has room.
// A byte yields at most two events (data or error, then buffer end); the output
// register hands out one event per cycle while rsp_pop takes each one.
// First event of a byte passes the queue, then the output register, to reach rsp_item.
// Reset is synchronous and clears parse state, queue pointers and output valid at once.
// req_full follows the queue only; rsp_pop stalls the output register alone.

module protobuf_wire_stream_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  pwsp_pkg::req_type req_item,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output pwsp_pkg::rsp_type rsp_item
);
   import pwsp_pkg::*;

   logic      q_full;
   logic      q_push;
   entry_type q_entry;
   logic      q_empty;
   logic      q_pop;
   entry_type q_head;

   assign req_full = q_full;

   pwsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   pwsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   pwsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

endmodule

>>> src/pwsp_front.sv
`timescale 1ns / 1ps

module pwsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  pwsp_pkg::req_type   req_item,
   input  logic                q_full,
   output logic                q_push,
   output pwsp_pkg::entry_type q_entry
);
   import pwsp_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [VALUE_W-1:0]  accum_ff, accum_in;
   logic [VIDX_W-1:0]   vidx_ff, vidx_in;
   logic [FIELD_W-1:0]  field_ff, field_in;
   logic [2:0]          wt_ff, wt_in;
   logic [VALUE_W-1:0]  remain_ff, remain_in;

   logic                accept;
   logic [6:0]          shamt;
   logic [VALUE_W-1:0]  acc_new;
   logic                cont;
   logic                too_long;
   logic [2:0]          err;
   logic                mid;
   logic                err_phase;
   logic                prim_valid;
   rsp_type             prim;

   assign accept   = req_push && !q_full;
   assign cont     = req_item.data_byte[7];
   assign too_long = cont && (vidx_ff == VIDX_LAST);
   assign shamt    = 7'({3'd0, vidx_ff} * 7'd7);
   assign acc_new  = accum_ff | ({{(VALUE_W-7){1'b0}}, req_item.data_byte[6:0]} << shamt);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         accum_ff  <= '0;
         vidx_ff   <= '0;
         field_ff  <= '0;
         wt_ff     <= '0;
         remain_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         vidx_ff   <= vidx_in;
         field_ff  <= field_in;
         wt_ff     <= wt_in;
         remain_ff <= remain_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      accum_in   = accum_ff;
      vidx_in    = vidx_ff;
      field_in   = field_ff;
      wt_in      = wt_ff;
      remain_in  = remain_ff;
      err        = ERR_NONE;
      mid        = 1'b0;
      err_phase  = 1'b0;
      prim_valid = 1'b0;
      prim       = '0;

      unique case (phase_ff)
         PH_TAG: begin
            if (cont) begin
               if (too_long) begin
                  err = ERR_VARINT_LONG;
               end else begin
                  mid      = 1'b1;
                  accum_in = acc_new;
                  vidx_in  = vidx_ff + 1'b1;
               end
            end else begin
               accum_in = '0;
               vidx_in  = '0;
               field_in = acc_new[FIELD_W+2:3];
               wt_in    = acc_new[2:0];
               if (acc_new[FIELD_W+2:3] == '0) begin
                  err = ERR_FIELD_ZERO;
               end else begin
                  unique case (acc_new[2:0])
                     WT_VARINT: phase_in = PH_VAL;
                     WT_FIXED64: begin
                        phase_in  = PH_PAY;
                        remain_in = FIXED64_BYTES;
                     end
                     WT_LENGTH: phase_in = PH_LEN;
                     WT_FIXED32: begin
                        phase_in  = PH_PAY;
                        remain_in = FIXED32_BYTES;
                     end
                     default: err = ERR_WIRE_TYPE;
                  endcase
               end
            end
         end
         PH_VAL, PH_LEN: begin
            if (cont) begin
               if (too_long) begin
                  err = ERR_VARINT_LONG;
               end else begin
                  mid      = 1'b1;
                  accum_in = acc_new;
                  vidx_in  = vidx_ff + 1'b1;
               end
            end else begin
               accum_in          = '0;
               vidx_in           = '0;
               prim_valid        = 1'b1;
               prim.field_number = field_ff;
               prim.wire_type    = wt_ff;
               prim.field_value  = acc_new;
               if (phase_ff == PH_VAL) begin
                  prim.event_kind = EV_VARINT;
                  phase_in        = PH_TAG;
               end else begin
                  prim.event_kind = EV_LENGTH;
                  if (acc_new == '0) begin
                     phase_in = PH_TAG;
                  end else begin
                     phase_in  = PH_PAY;
                     remain_in = acc_new;
                  end
               end
            end
         end
         PH_PAY: begin
            prim_valid        = 1'b1;
            prim.event_kind   = EV_PAYLOAD;
            prim.field_number = field_ff;
            prim.wire_type    = wt_ff;
            prim.payload_byte = req_item.data_byte;
            remain_in         = remain_ff - 1'b1;
            if (remain_ff == VALUE_W'(1)) begin
               phase_in = PH_TAG;
            end
         end
         PH_ERR: err_phase = 1'b1;
         default: err_phase = 1'b1;
      endcase

      if (!err_phase && err == ERR_NONE && req_item.final_byte &&
          (phase_in != PH_TAG || mid)) begin
         err = ERR_TRUNCATED;
      end

      if (err != ERR_NONE) begin
         prim_valid        = 1'b1;
         prim              = '0;
         prim.event_kind   = EV_ERROR;
         prim.field_number = field_in;
         prim.wire_type    = wt_in;
         prim.error_code   = err;
         phase_in          = PH_ERR;
      end else if (!err_phase && phase_in == PH_TAG && !mid) begin
         field_in = '0;
         wt_in    = '0;
      end

      prim.run_last = !req_item.final_byte;

      if (req_item.final_byte) begin
         phase_in  = PH_TAG;
         accum_in  = '0;
         vidx_in   = '0;
         field_in  = '0;
         wt_in     = '0;
         remain_in = '0;
      end
   end

   assign q_push            = accept && (prim_valid || req_item.final_byte);
   assign q_entry.prim_valid = prim_valid;
   assign q_entry.prim       = prim;
   assign q_entry.end_valid  = req_item.final_byte;

endmodule

>>> src/pwsp_queue.sv
`timescale 1ns / 1ps

module pwsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pwsp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output pwsp_pkg::entry_type head
);
   import pwsp_pkg::*;

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    wr;
   logic                    rd;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign wr    = push && !full;
   assign rd    = pop && !empty;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> src/pwsp_back.sv
`timescale 1ns / 1ps
`include "protobuf_wire_stream_parser_unit_defines.svh"

module pwsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  pwsp_pkg::entry_type q_head,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output pwsp_pkg::rsp_type   rsp_item
);
   import pwsp_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    half_ff, half_in;
   logic    load;
   rsp_type end_rsp;

   always_comb begin
      end_rsp            = '0;
      end_rsp.event_kind = EV_END;
      end_rsp.run_last   = 1'b1;
   end

   assign load = !out_valid_ff || rsp_pop;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      half_in      = half_ff;
      q_pop        = 1'b0;
      if (load) begin
         if (!q_empty) begin
            out_valid_in = 1'b1;
            if (q_head.prim_valid && !half_ff) begin
               out_in = q_head.prim;
               if (q_head.end_valid) begin
                  half_in = 1'b1;
               end else begin
                  q_pop = 1'b1;
               end
            end else begin
               out_in  = end_rsp;
               half_in = 1'b0;
               q_pop   = 1'b1;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   `PWSP_ASSERT_NOW(a_half_head, half_ff, !q_empty && q_head.prim_valid && q_head.end_valid, "split entry lost its head")
   `PWSP_ASSERT_NOW(a_end_last, out_valid_ff && out_ff.event_kind == EV_END, out_ff.run_last, "buffer end not marked last")
   `PWSP_ASSERT_NEXT(a_end_follows, out_valid_ff && rsp_pop && !out_ff.run_last, out_valid_ff && out_ff.event_kind == EV_END, "buffer end did not follow")

endmodule

>>> sim/protobuf_wire_stream_parser_unit_tb.sv
`timescale 1ns / 1ps

module protobuf_wire_stream_parser_unit_tb;
   import pwsp_pkg::*;

   localparam int TARGET_BYTES = 1400;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 20;

   typedef enum logic [1:0] {
      VI_MORE,
      VI_DONE,
      VI_LONG
   } vstep_type;

   typedef struct {
      req_type it;
      int      n;
      rsp_type e0;
      rsp_type e1;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_item  = '0;
   logic    rsp_pop   = 1'b0;
   logic    rsp_empty;
   rsp_type rsp_item;

   phase_type          ph     = PH_TAG;
   logic [VALUE_W-1:0] acc    = '0;
   logic [6:0]         shift  = '0;
   logic [FIELD_W-1:0] cur_f  = '0;
   logic [2:0]         cur_wt = '0;
   logic [VALUE_W-1:0] remain = '0;

   rsp_type      pending_events[$];
   stim_row_type stim_rows[$];
   logic [7:0]   msg_bytes[$];

   int  n_fail      = 0;
   int  n_items     = 0;
   int  n_bufs      = 0;
   int  n_events    = 0;
   int  n_err_ev    = 0;
   int  n_end_ev    = 0;
   int  idle_cycles = 0;
   bit  tx_burst    = 1'b0;

   protobuf_wire_stream_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type mk_ev(logic [2:0] kind, logic [FIELD_W-1:0] fnum,
                                     logic [2:0] wt, logic [VALUE_W-1:0] val,
                                     logic [7:0] pb, logic [2:0] code, logic last);
      rsp_type e;
      e.event_kind   = kind;
      e.field_number = fnum;
      e.wire_type    = wt;
      e.field_value  = val;
      e.payload_byte = pb;
      e.error_code   = code;
      e.run_last     = last;
      return e;
   endfunction

   function automatic vstep_type varint_step(logic [7:0] b);
      acc = acc | (VALUE_W'(b[6:0]) << shift[5:0]);
      if (!b[7])
         return VI_DONE;
      if (shift >= 7'd63)
         return VI_LONG;
      shift = shift + 7'd7;
      return VI_MORE;
   endfunction

   // running parse of one request; expected events go to pending_events
   task automatic parse_byte(input req_type it, output int n, output bit ignored);
      logic [7:0]         b;
      logic               fin;
      logic [2:0]         err;
      bit                 mid;
      bit                 in_err;
      vstep_type          r;
      logic [VALUE_W-1:0] key;
      rsp_type            evs[$];
      rsp_type            tmp;
      b      = it.data_byte;
      fin    = it.final_byte;
      err    = ERR_NONE;
      mid    = 1'b0;
      in_err = 1'b0;
      case (ph)
         PH_TAG: begin
            r = varint_step(b);
            if (r == VI_LONG) begin
               err = ERR_VARINT_LONG;
            end else if (r == VI_DONE) begin
               key    = acc;
               acc    = '0;
               shift  = '0;
               cur_f  = key[34:3];
               cur_wt = key[2:0];
               if (cur_f == '0) begin
                  err = ERR_FIELD_ZERO;
               end else begin
                  case (cur_wt)
                     WT_VARINT:  ph = PH_VAL;
                     WT_FIXED64: begin
                        ph     = PH_PAY;
                        remain = FIXED64_BYTES;
                     end
                     WT_LENGTH:  ph = PH_LEN;
                     WT_FIXED32: begin
                        ph     = PH_PAY;
                        remain = FIXED32_BYTES;
                     end
                     default:    err = ERR_WIRE_TYPE;
                  endcase
               end
            end else begin
               mid = 1'b1;
            end
         end
         PH_VAL, PH_LEN: begin
            r = varint_step(b);
            if (r == VI_LONG) begin
               err = ERR_VARINT_LONG;
            end else if (r == VI_DONE) begin
               key   = acc;
               acc   = '0;
               shift = '0;
               if (ph == PH_VAL) begin
                  evs.push_back(mk_ev(EV_VARINT, cur_f, cur_wt, key, 8'h00, ERR_NONE, 1'b0));
                  ph = PH_TAG;
               end else begin
                  evs.push_back(mk_ev(EV_LENGTH, cur_f, cur_wt, key, 8'h00, ERR_NONE, 1'b0));
                  if (key == '0) begin
                     ph = PH_TAG;
                  end else begin
                     ph     = PH_PAY;
                     remain = key;
                  end
               end
            end else begin
               mid = 1'b1;
            end
         end
         PH_PAY: begin
            evs.push_back(mk_ev(EV_PAYLOAD, cur_f, cur_wt, '0, b, ERR_NONE, 1'b0));
            remain = remain - 1'b1;
            if (remain == '0)
               ph = PH_TAG;
         end
         default: in_err = 1'b1;
      endcase

      if (!in_err && err == ERR_NONE && fin && (ph != PH_TAG || mid))
         err = ERR_TRUNCATED;

      if (err != ERR_NONE) begin
         evs = {};
         evs.push_back(mk_ev(EV_ERROR, cur_f, cur_wt, '0, 8'h00, err, 1'b0));
         ph = PH_ERR;
      end else if (!in_err && ph == PH_TAG && !mid) begin
         cur_f  = '0;
         cur_wt = '0;
      end

      if (fin) begin
         ph     = PH_TAG;
         acc    = '0;
         shift  = '0;
         cur_f  = '0;
         cur_wt = '0;
         remain = '0;
         evs.push_back(mk_ev(EV_END, '0, '0, '0, 8'h00, ERR_NONE, 1'b0));
      end

      if (evs.size() > 0) begin
         tmp = evs.pop_back();
         tmp.run_last = 1'b1;
         evs.push_back(tmp);
      end
      n       = evs.size();
      ignored = in_err && !fin;
      foreach (evs[i])
         pending_events.push_back(evs[i]);
   endtask

   task automatic send(input req_type it, output int n);
      int gap;
      bit ign;
      gap = tx_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      parse_byte(it, n, ign);
      if (!ign)
         n_items++;
   endtask

   task automatic add_row(input logic [7:0] b, input logic f, input int n,
                          input rsp_type e0, input rsp_type e1);
      stim_row_type row;
      row.it.data_byte  = b;
      row.it.final_byte = f;
      row.n  = n;
      row.e0 = e0;
      row.e1 = e1;
      stim_rows.push_back(row);
   endtask

   task automatic report_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      n_fail++;
   endtask

   task automatic check_event(input rsp_type got);
      rsp_type want;
      if (pending_events.size() == 0) begin
         $display("%0t: event with none expected, expected nothing, got kind %0d",
                  $time, got.event_kind);
         n_fail++;
      end else begin
         want = pending_events.pop_front();
         n_events++;
         if (want.event_kind == EV_ERROR)
            n_err_ev++;
         if (want.event_kind == EV_END)
            n_end_ev++;
         if (got.event_kind !== want.event_kind)
            report_field("event_kind", want.event_kind, got.event_kind);
         if (got.field_number !== want.field_number)
            report_field("field_number", want.field_number, got.field_number);
         if (got.wire_type !== want.wire_type)
            report_field("wire_type", want.wire_type, got.wire_type);
         if (got.field_value !== want.field_value)
            report_field("field_value", want.field_value, got.field_value);
         if (got.payload_byte !== want.payload_byte)
            report_field("payload_byte", want.payload_byte, got.payload_byte);
         if (got.error_code !== want.error_code)
            report_field("error_code", want.error_code, got.error_code);
         if (got.run_last !== want.run_last)
            report_field("run_last", want.run_last, got.run_last);
      end
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      int w;
      logic [VALUE_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return VALUE_W'($urandom_range(0, 127));
         default: begin
            w = $urandom_range(1, 64);
            if (w < 64)
               v = v & ((64'd1 << w) - 64'd1);
            return v;
         end
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] rand_field();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return ($urandom == 0) ? 32'd1 : FIELD_W'($urandom);
         default: return FIELD_W'($urandom_range(1, 31));
      endcase
   endfunction

   // long form: ten bytes, spare bits above bit 63 filled at random
   task automatic put_varint(input logic [VALUE_W-1:0] v, input bit long_form);
      logic [VALUE_W-1:0] rest;
      int i;
      rest = v;
      if (long_form) begin
         for (i = 0; i < 9; i++) begin
            msg_bytes.push_back({1'b1, rest[6:0]});
            rest = rest >> 7;
         end
         msg_bytes.push_back({1'b0, 6'($urandom), rest[0]});
      end else begin
         while (rest > 64'd127) begin
            msg_bytes.push_back({1'b1, rest[6:0]});
            rest = rest >> 7;
         end
         msg_bytes.push_back({1'b0, rest[6:0]});
      end
   endtask

   task automatic put_tag(input logic [FIELD_W-1:0] f, input logic [2:0] wt);
      logic [28:0] hi;
      hi = ($urandom_range(0, 7) == 0) ? 29'($urandom) : '0;
      put_varint({hi, f, wt}, $urandom_range(0, 15) == 0);
   endtask

   task automatic put_noise(input int lo, input int hi);
      repeat ($urandom_range(lo, hi))
         msg_bytes.push_back(8'($urandom));
   endtask

   task automatic put_field();
      logic [2:0] wt;
      int len;
      case ($urandom_range(0, 3))
         0:       wt = WT_VARINT;
         1:       wt = WT_FIXED64;
         2:       wt = WT_LENGTH;
         default: wt = WT_FIXED32;
      endcase
      put_tag(rand_field(), wt);
      case (wt)
         WT_VARINT:  put_varint(rand_value(), $urandom_range(0, 15) == 0);
         WT_FIXED64: put_noise(8, 8);
         WT_FIXED32: put_noise(4, 4);
         default: begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24)
                                              : $urandom_range(0, 6);
            put_varint(VALUE_W'(len), $urandom_range(0, 15) == 0);
            put_noise(len, len);
         end
      endcase
   endtask

   task automatic build_buffer();
      logic [2:0] bad_wt;
      int cut;
      msg_bytes = {};
      repeat ($urandom_range(0, 4))
         put_field();
      case ($urandom_range(0, 15))
         10, 11: begin
            put_field();
            if (msg_bytes.size() > 1) begin
               cut = $urandom_range(1, msg_bytes.size() - 1);
               msg_bytes = msg_bytes[0:cut-1];
            end
         end
         12: begin
            put_varint({29'b0, rand_field(), WT_LENGTH}, 1'b0);
            put_varint({$urandom, $urandom} | 64'h1000, $urandom_range(0, 3) == 0);
            put_noise(0, 5);
         end
         13: begin
            if ($urandom_range(0, 1) == 0) begin
               put_varint({29'($urandom_range(0, 1) ? $urandom : 0), 32'b0, 3'($urandom)},
                          1'b0);
            end else begin
               bad_wt = 3'($urandom_range(0, 3));
               bad_wt = (bad_wt < 3'd2) ? bad_wt + 3'd3 : bad_wt + 3'd4;
               put_tag(rand_field(), bad_wt);
            end
            put_noise(0, 5);
         end
         14: begin
            if ($urandom_range(0, 1) == 0)
               put_tag(rand_field(), WT_VARINT);
            repeat ($urandom_range(10, 12))
               msg_bytes.push_back({1'b1, 7'($urandom)});
            put_noise(0, 5);
         end
         15: put_noise(1, 12);
         default: put_field();
      endcase
   endtask

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or event moved for %0d cycles", $time, STALL_LIMIT);
         $display("protobuf_wire_stream_parser_unit_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : drain
      int gap;
      int quiet;
      quiet = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (quiet > 0) begin
            gap = 0;
            quiet--;
         end else begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 19) == 0)
               quiet = $urandom_range(20, 60);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         check_event(rsp_item);
      end
   end

   initial begin : stimulus
      req_type it;
      int n;
      int i;

      add_row(8'h08, 1'b1, 2,
              mk_ev(EV_ERROR, 32'd1, WT_VARINT, '0, 8'h00, ERR_TRUNCATED, 1'b0),
              mk_ev(EV_END, '0, '0, '0, 8'h00, ERR_NONE, 1'b1));
      add_row(8'h00, 1'b0, 1,
              mk_ev(EV_ERROR, '0, '0, '0, 8'h00, ERR_FIELD_ZERO, 1'b1), '0);
      add_row(8'h55, 1'b1, 1, mk_ev(EV_END, '0, '0, '0, 8'h00, ERR_NONE, 1'b1), '0);
      add_row(8'h0f, 1'b0, 1,
              mk_ev(EV_ERROR, 32'd1, 3'd7, '0, 8'h00, ERR_WIRE_TYPE, 1'b1), '0);
      add_row(8'hff, 1'b1, 1, mk_ev(EV_END, '0, '0, '0, 8'h00, ERR_NONE, 1'b1), '0);
      add_row(8'hff, 1'b1, 2,
              mk_ev(EV_ERROR, '0, '0, '0, 8'h00, ERR_TRUNCATED, 1'b0),
              mk_ev(EV_END, '0, '0, '0, 8'h00, ERR_NONE, 1'b1));
      // largest field number, then a zero value
      add_row(8'hf8, 1'b0, -1, '0, '0);
      add_row(8'hff, 1'b0, -1, '0, '0);
      add_row(8'hff, 1'b0, -1, '0, '0);
      add_row(8'hff, 1'b0, -1, '0, '0);
      add_row(8'h7f, 1'b0, -1, '0, '0);
      add_row(8'h00, 1'b0, -1, '0, '0);
      // empty length-delimited field
      add_row(8'h12, 1'b0, -1, '0, '0);
      add_row(8'h00, 1'b0, -1, '0, '0);
      // eleven-byte value varint
      add_row(8'h08, 1'b0, -1, '0, '0);
      repeat (9)
         add_row(8'hff, 1'b0, -1, '0, '0);
      add_row(8'hff, 1'b0, 1,
              mk_ev(EV_ERROR, 32'd1, WT_VARINT, '0, 8'h00, ERR_VARINT_LONG, 1'b1), '0);
      add_row(8'h00, 1'b1, 1, mk_ev(EV_END, '0, '0, '0, 8'h00, ERR_NONE, 1'b1), '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) begin
         send(stim_rows[r].it, n);
         if (stim_rows[r].n >= 0) begin
            repeat (n) void'(pending_events.pop_back());
            if (stim_rows[r].n > 0)
               pending_events.push_back(stim_rows[r].e0);
            if (stim_rows[r].n > 1)
               pending_events.push_back(stim_rows[r].e1);
         end
      end

      while (n_items < TARGET_BYTES) begin
         build_buffer();
         if (msg_bytes.size() == 0)
            msg_bytes.push_back(8'($urandom));
         tx_burst = ($urandom_range(0, 5) == 0);
         for (i = 0; i < msg_bytes.size(); i++) begin
            it.data_byte  = msg_bytes[i];
            it.final_byte = (i == msg_bytes.size() - 1);
            send(it, n);
         end
         n_bufs++;
      end
      req_push <= 1'b0;

      while (pending_events.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("parsed %0d live bytes over %0d random buffers plus the directed rows",
               n_items, n_bufs);
      $display("checked %0d events: %0d errors, %0d buffer ends", n_events, n_err_ev,
               n_end_ev);
      if (n_fail == 0 && pending_events.size() == 0)
         $display("protobuf_wire_stream_parser_unit_tb OK");
      else
         $display("protobuf_wire_stream_parser_unit_tb NOT OK");
      $finish;
   end

endmodule
